// ===== src/shortest_queue_dispatcher_top_assert.svh =====
// assertion macros shared by the dispatcher checker
`ifndef SHORTEST_QUEUE_DISPATCHER_TOP_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SQD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SQD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sqd_pkg.sv =====
// types and constants of the shortest queue dispatcher
`timescale 1ns / 1ps

package sqd_pkg;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic {
        FUNC_ARRIVAL = 1'b0,
        FUNC_DEPART  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SELECT,
        S_JOIN,
        S_DREAD,
        S_DLEAVE
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [3:0]  queue_index;
        logic [15:0] draw;
    } t_sqd_in;

    typedef struct packed {
        logic [3:0]  chosen_queue;
        logic [15:0] new_length;
        logic [4:0]  tie_count;
        logic        start_service;
        t_status     status;
    } t_sqd_out;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctrl;

endpackage

// ===== src/sqd_store.sv =====
// queue length memory with per-entry valid bits, unwritten entries read as zero
`timescale 1ns / 1ps

module sqd_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sqd_pkg::t_mem_ctrl    i_ctrl,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DW-1:0]         i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DW-1:0]         o_rd_data
);
    import sqd_pkg::*;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== src/shortest_queue_dispatcher_top.sv =====
// shortest queue dispatcher: join-the-shortest-queue with random tie break
//
// usage
//   input channel: present i_item with start high; the item is taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been loaded into the output register.
//   result channel: o_result is shown for exactly one cycle with o_valid
//   high. the receiver cannot stall, so every result must be taken then.
//   config: i_cfg_we with i_cfg_data writes queues_in_use; write it only
//   while busy is low and no result is pending.
// sequence, with n the number of queues in use
//   arrival: one scan over the n queues for minimum and ties, one multiply,
//   one scan for the chosen tie.
//   departure: one memory read, one update.
//   both scans share one length comparator and one memory read port, one
//   counter per cycle; a new item is taken the cycle o_valid shows.
// reset
//   i_rst_n low (synchronous) empties all queues and sets queues_in_use to
//   16; valid bits make the counters read as zero at once, no clear pass.
`timescale 1ns / 1ps

module shortest_queue_dispatcher_top #(
    parameter int MAX_QUEUES   = 16,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sqd_pkg::t_sqd_in               i_item,
    output logic                           o_valid,
    output sqd_pkg::t_sqd_out              o_result,
    input  logic                           i_cfg_we,
    input  logic [sqd_pkg::CFG_W-1:0]      i_cfg_data
);
    import sqd_pkg::*;

    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int NW = $clog2(MAX_QUEUES + 1);
    localparam int CW = NW + CFG_W;
    localparam int PW = 16 + NW;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_cfg;
    logic [15:0]             r_draw, n_draw;
    logic [3:0]              r_qidx, n_qidx;
    logic [NW-1:0]           r_idx, n_idx;
    logic                    r_pend, n_pend;
    logic [QW-1:0]           r_pidx, n_pidx;
    logic [LENGTH_WIDTH-1:0] r_min, n_min;
    logic [NW-1:0]           r_ties, n_ties;
    logic [NW-1:0]           r_pick, n_pick;
    logic [NW-1:0]           r_seen, n_seen;
    logic [QW-1:0]           r_chosen, n_chosen;
    t_sqd_out                r_out, n_out;
    logic                    r_out_vld, n_out_vld;

    logic [NW-1:0]           used_cnt;
    logic [QW-1:0]           last_idx;
    logic                    issue;
    logic                    in_range;
    logic                    len_lt, len_eq;
    logic [PW-1:0]           product;
    logic [LENGTH_WIDTH-1:0] join_len, leave_len;

    t_mem_ctrl               mem_ctrl;
    logic [QW-1:0]           wr_addr, rd_addr;
    logic [LENGTH_WIDTH-1:0] wr_data, rd_data;

    sqd_store #(
        .DEPTH (MAX_QUEUES),
        .AW    (QW),
        .DW    (LENGTH_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mem_ctrl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // register value 0 acts as one queue, values above the queue count clamp
    always_comb begin
        if (r_cfg == '0) begin
            used_cnt = NW'(1);
        end else if (CW'(r_cfg) > CW'(MAX_QUEUES)) begin
            used_cnt = NW'(MAX_QUEUES);
        end else begin
            used_cnt = NW'(r_cfg);
        end
    end

    assign last_idx  = QW'(used_cnt - 1'b1);
    assign issue     = (r_idx < used_cnt);
    assign in_range  = (CW'(r_qidx) < CW'(used_cnt));
    // shared comparator for both scans
    assign len_lt    = (rd_data < r_min);
    assign len_eq    = (rd_data == r_min);
    assign product   = PW'(r_draw) * PW'(r_ties);
    assign join_len  = r_min + 1'b1;
    assign leave_len = rd_data - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_draw    = r_draw;
        n_qidx    = r_qidx;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_min     = r_min;
        n_ties    = r_ties;
        n_pick    = r_pick;
        n_seen    = r_seen;
        n_chosen  = r_chosen;
        n_out     = r_out;
        n_out_vld = 1'b0;
        mem_ctrl  = '0;
        rd_addr   = r_idx[QW-1:0];
        wr_addr   = r_chosen;
        wr_data   = join_len;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_draw  = i_item.draw;
                    n_qidx  = i_item.queue_index;
                    n_idx   = '0;
                    n_seen  = '0;
                    n_state = (i_item.func == FUNC_DEPART) ? S_DREAD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    mem_ctrl.rd_en = 1'b1;
                    n_idx          = r_idx + 1'b1;
                    n_pend         = 1'b1;
                    n_pidx         = r_idx[QW-1:0];
                end
                // read data comes back in the cycle after its address
                if (r_pend) begin
                    if (r_pidx == '0 || len_lt) begin
                        n_min  = rd_data;
                        n_ties = NW'(1);
                    end else if (len_eq) begin
                        n_ties = r_ties + 1'b1;
                    end
                    if (r_pidx == last_idx) begin
                        n_pend  = 1'b0;
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                n_pick  = product[PW-1:16];
                n_idx   = '0;
                n_state = S_SELECT;
            end
            S_SELECT: begin
                if (issue) begin
                    mem_ctrl.rd_en = 1'b1;
                    n_idx          = r_idx + 1'b1;
                    n_pend         = 1'b1;
                    n_pidx         = r_idx[QW-1:0];
                end
                if (r_pend && len_eq) begin
                    if (r_seen == r_pick) begin
                        n_chosen = r_pidx;
                        n_pend   = 1'b0;
                        n_state  = S_JOIN;
                    end else begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end
            S_JOIN: begin
                n_out.chosen_queue = 4'(r_chosen);
                n_out.tie_count    = 5'(r_ties);
                if (r_min == LEN_MAX) begin
                    n_out.new_length    = 16'(r_min);
                    n_out.start_service = 1'b0;
                    n_out.status        = STAT_FULL;
                end else begin
                    mem_ctrl.wr_en      = 1'b1;
                    n_out.new_length    = 16'(join_len);
                    n_out.start_service = (r_min == '0);
                    n_out.status        = STAT_OK;
                end
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_DREAD: begin
                rd_addr = QW'(r_qidx);
                if (in_range) begin
                    mem_ctrl.rd_en = 1'b1;
                end
                n_state = S_DLEAVE;
            end
            S_DLEAVE: begin
                wr_addr             = QW'(r_qidx);
                wr_data             = leave_len;
                n_out.chosen_queue  = r_qidx;
                n_out.tie_count     = '0;
                n_out.new_length    = '0;
                n_out.start_service = 1'b0;
                if (!in_range) begin
                    n_out.status = STAT_RANGE;
                end else if (rd_data == '0) begin
                    n_out.status = STAT_EMPTY;
                end else begin
                    mem_ctrl.wr_en      = 1'b1;
                    n_out.new_length    = 16'(leave_len);
                    n_out.start_service = (leave_len != '0);
                    n_out.status        = STAT_OK;
                end
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw   <= n_draw;
        r_qidx   <= n_qidx;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_min    <= n_min;
        r_ties   <= n_ties;
        r_pick   <= n_pick;
        r_seen   <= n_seen;
        r_chosen <= n_chosen;
        r_out    <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ===== src/sqd_checker.sv =====
// port-level checks of the dispatcher, bound to the top level
`timescale 1ns / 1ps
`include "shortest_queue_dispatcher_top_assert.svh"

module sqd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input sqd_pkg::t_sqd_out  o_result
);
    import sqd_pkg::*;

    `SQD_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `SQD_ASSERT_IMP(a_result_idle, o_valid, !busy, "result shown while still busy")
    `SQD_ASSERT_NXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `SQD_ASSERT_IMP(a_refused_no_start, o_valid && (o_result.status != STAT_OK), !o_result.start_service, "service started on refused transfer")

endmodule

bind shortest_queue_dispatcher_top sqd_checker u_sqd_checker (.*);

// ===== verif/tb_top.sv =====
// self-checking testbench for the shortest queue dispatcher
`timescale 1ns / 1ps

import sqd_pkg::*;

// tracks queue lengths, predicts each dispatch and checks results in order
class dispatch_checker;
    logic [15:0]    queue_len [16];
    logic [CFG_W-1:0] queues_cfg;
    t_sqd_out       due_dispatches [$];
    int             errors;

    function new();
        queues_cfg = CFG_RESET;
        foreach (queue_len[i]) queue_len[i] = '0;
        errors = 0;
    endfunction

    function void set_cfg(logic [CFG_W-1:0] value);
        queues_cfg = value;
    endfunction

    // zero acts as one, anything above sixteen as sixteen
    function int active_queues();
        if (queues_cfg == 0) return 1;
        if (queues_cfg > 16) return 16;
        return int'(queues_cfg);
    endfunction

    function int pending();
        return due_dispatches.size();
    endfunction

    function void note_transfer(t_sqd_in it);
        int       span;
        int       tied;
        int       slot;
        int       tally;
        int       target;
        bit       found;
        logic [15:0] shortest;
        t_sqd_out exp_res;
        span = active_queues();
        exp_res = '0;
        exp_res.status = STAT_OK;
        if (it.func == FUNC_ARRIVAL) begin
            shortest = queue_len[0];
            tied = 1;
            for (int i = 1; i < span; i++) begin
                if (queue_len[i] < shortest) begin
                    shortest = queue_len[i];
                    tied = 1;
                end else if (queue_len[i] == shortest) begin
                    tied++;
                end
            end
            // draw scaled by tie count selects one tied queue in index order
            slot = (int'(it.draw) * tied) >>> 16;
            tally = 0;
            target = 0;
            found = 0;
            for (int i = 0; i < span; i++) begin
                if (!found && queue_len[i] == shortest) begin
                    if (tally == slot) begin
                        target = i;
                        found = 1;
                    end
                    tally++;
                end
            end
            exp_res.chosen_queue = target[3:0];
            exp_res.tie_count = tied[4:0];
            if (queue_len[target] == 16'hFFFF) begin
                exp_res.status = STAT_FULL;
                exp_res.new_length = queue_len[target];
            end else begin
                queue_len[target] = queue_len[target] + 16'd1;
                exp_res.new_length = queue_len[target];
                exp_res.start_service = (queue_len[target] == 16'd1);
            end
        end else begin
            exp_res.chosen_queue = it.queue_index;
            if (int'(it.queue_index) >= span) begin
                exp_res.status = STAT_RANGE;
            end else if (queue_len[it.queue_index] == 0) begin
                exp_res.status = STAT_EMPTY;
            end else begin
                queue_len[it.queue_index] = queue_len[it.queue_index] - 16'd1;
                exp_res.new_length = queue_len[it.queue_index];
                exp_res.start_service = (queue_len[it.queue_index] != 0);
            end
        end
        due_dispatches.push_back(exp_res);
    endfunction

    function void check_result(t_sqd_out act);
        t_sqd_out exp_res;
        if (due_dispatches.size() == 0) begin
            errors++;
            $display("%0t unexpected result: q=%0d len=%0d ties=%0d start=%0b status=%0d",
                     $time, act.chosen_queue, act.new_length, act.tie_count,
                     act.start_service, act.status);
            return;
        end
        exp_res = due_dispatches.pop_front();
        if (act.chosen_queue !== exp_res.chosen_queue || act.new_length !== exp_res.new_length
                || act.tie_count !== exp_res.tie_count
                || act.start_service !== exp_res.start_service
                || act.status !== exp_res.status) begin
            errors++;
            $display("%0t mismatch: expected q=%0d len=%0d ties=%0d start=%0b status=%0d",
                     $time, exp_res.chosen_queue, exp_res.new_length, exp_res.tie_count,
                     exp_res.start_service, exp_res.status);
            $display("%0t            actual q=%0d len=%0d ties=%0d start=%0b status=%0d",
                     $time, act.chosen_queue, act.new_length, act.tie_count,
                     act.start_service, act.status);
        end
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 60;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_sqd_in          i_item;
    logic             o_valid;
    t_sqd_out         o_result;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    dispatch_checker sb;

    shortest_queue_dispatcher_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_result);
        end
    end

    // ends the run when no transfer of either kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && ((start && !busy) || o_valid)) quiet = 0;
            else quiet++;
        end
        $display("shortest_queue_dispatcher_top test failed");
        $finish;
    end

    // holds the item until the block takes it; returns at the accepting edge
    task automatic send_item(t_func f, logic [3:0] qidx, logic [15:0] draw);
        @(negedge i_clk);
        start = 1'b1;
        i_item.func = f;
        i_item.queue_index = qidx;
        i_item.draw = draw;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_transfer(i_item);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // register write only once every result is back and the block is idle
    task automatic write_queues_cfg(logic [CFG_W-1:0] value);
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.set_cfg(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_random_item();
        int          span;
        t_func       f;
        logic [3:0]  qidx;
        logic [15:0] draw;
        span = sb.active_queues();
        f = ($urandom_range(0, 99) < 55) ? FUNC_ARRIVAL : FUNC_DEPART;
        if ($urandom_range(0, 4) == 0) qidx = 4'($urandom_range(0, 15));
        else qidx = 4'($urandom_range(0, span - 1));
        case ($urandom_range(0, 7))
            0: draw = 16'h0000;
            1: draw = 16'hFFFF;
            default: draw = 16'($urandom_range(0, 65535));
        endcase
        send_item(f, qidx, draw);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_cfg [10];
        bit gaps_on;
        sb = new();
        phase_cfg = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd17, 5'd12, 5'd16};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty departures, extreme draws over sixteen tied queues
        send_item(FUNC_DEPART, 4'd0, 16'h0000);
        send_item(FUNC_DEPART, 4'd15, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 4'd15, 16'h0000);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 4'd7, 16'h8000);
        send_item(FUNC_DEPART, 4'd0, 16'h1234);
        send_item(FUNC_DEPART, 4'd15, 16'h0001);
        // single queue: service start on join and on leave, out of range index
        write_queues_cfg(5'd1);
        send_item(FUNC_ARRIVAL, 4'd3, 16'h5555);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hAAAA);
        send_item(FUNC_DEPART, 4'd0, 16'h0000);
        send_item(FUNC_DEPART, 4'd5, 16'h0000);
        send_item(FUNC_DEPART, 4'd15, 16'h0000);
        send_item(FUNC_DEPART, 4'd0, 16'h0000);
        send_item(FUNC_DEPART, 4'd0, 16'h0000);
        // register values outside the legal range, then two queues
        write_queues_cfg(5'd0);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);
        send_item(FUNC_DEPART, 4'd1, 16'h0000);
        write_queues_cfg(5'd31);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);
        send_item(FUNC_DEPART, 4'd15, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 4'd9, 16'h7FFF);
        write_queues_cfg(5'd2);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);
        send_item(FUNC_DEPART, 4'd2, 16'h0000);

        for (int ph = 0; ph < 10; ph++) begin
            write_queues_cfg((ph == 8) ? 5'($urandom_range(0, 31)) : phase_cfg[ph]);
            // last stretch of the run goes without sender gaps
            gaps_on = (ph < 8) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 80; k++) begin
                if (gaps_on && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 17));
                end
                send_random_item();
            end
        end

        // single queue after the random run: join, leave and rejoin
        write_queues_cfg(5'd1);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 4'd15, 16'h0000);
        send_item(FUNC_DEPART, 4'd0, 16'h0000);
        send_item(FUNC_ARRIVAL, 4'd0, 16'h0000);
        send_item(FUNC_ARRIVAL, 4'd0, 16'hFFFF);

        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("shortest_queue_dispatcher_top test passed");
        end else begin
            $display("shortest_queue_dispatcher_top test failed");
        end
        $finish;
    end

endmodule
